// File: sv/lcnc_pkg.sv
`timescale 1ns / 1ps

package lcnc_pkg;

    localparam int CARD_W     = 63;
    localparam int CLASS_W    = 2;
    localparam int BIN_W      = 64;
    localparam int NIBBLES    = 20;
    localparam int BCD_W      = NIBBLES * 4;
    localparam int BITS_STEP  = 4;
    localparam int CONV_STEPS = BIN_W / BITS_STEP;
    localparam int SCAN_STEPS = NIBBLES / 2;
    localparam int CNT_W      = 4;
    localparam int LEN_W      = 5;

    localparam logic [CLASS_W-1:0] CLASS_INVALID = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_AMEX    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_MC      = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_VISA    = 2'd3;

    localparam logic [LEN_W-1:0] LEN_SHORT = 5'd13;
    localparam logic [LEN_W-1:0] LEN_AMEX  = 5'd15;
    localparam logic [LEN_W-1:0] LEN_LONG  = 5'd16;

    localparam logic [3:0] AMEX_LEAD  = 4'd3;
    localparam logic [3:0] AMEX_SEC_A = 4'd4;
    localparam logic [3:0] AMEX_SEC_B = 4'd7;
    localparam logic [3:0] MC_LEAD    = 4'd5;
    localparam logic [3:0] MC_SEC_LO  = 4'd1;
    localparam logic [3:0] MC_SEC_HI  = 4'd5;
    localparam logic [3:0] VISA_LEAD  = 4'd4;

    typedef struct packed {
        logic start;
        logic conv_step;
        logic scan_step;
        logic emit;
    } lcnc_cmd_t;

    typedef struct packed {
        logic out_free;
    } lcnc_status_t;

endpackage

// File: sv/lcnc_card_if.sv
`timescale 1ns / 1ps

interface lcnc_card_if
    import lcnc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CARD_W-1:0] card_number;

    modport source (output valid, output card_number, input ready);
    modport sink (input valid, input card_number, output ready);
endinterface

// File: sv/lcnc_class_if.sv
`timescale 1ns / 1ps

interface lcnc_class_if
    import lcnc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] card_class;

    modport source (output valid, output card_class, input ready);
    modport sink (input valid, input card_class, output ready);
endinterface

// File: sv/luhn_card_number_classifier.sv
`timescale 1ns / 1ps
// A word is accepted in the idle state. Its class word is registered once binary to
// decimal conversion (four bits a cycle) and Luhn scanning (two digits a cycle) are done
// and the output is free; only then does the controller return to idle for a new word.
// A new word is accepted while the previous class word still waits at the output.
// Reset is asynchronous and active low; it clears the controller and the output valid.
module luhn_card_number_classifier
    import lcnc_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    lcnc_card_if.sink    card,
    lcnc_class_if.source result
);

    lcnc_cmd_t    cmd;
    lcnc_status_t status;

    lcnc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .card_valid (card.valid),
        .card_ready (card.ready),
        .status     (status),
        .cmd        (cmd)
    );

    lcnc_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .card_number (card.card_number),
        .cmd         (cmd),
        .status      (status),
        .class_valid (result.valid),
        .class_ready (result.ready),
        .card_class  (result.card_class)
    );

endmodule

// File: sv/lcnc_ctrl.sv
`timescale 1ns / 1ps

module lcnc_ctrl
    import lcnc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         card_valid,
    output logic         card_ready,
    input  lcnc_status_t status,
    output lcnc_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(CONV_STEPS - 1);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(SCAN_STEPS - 1);

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        card_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                card_ready = 1'b1;
                if (card_valid)
                begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (cnt_reg == CONV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (cnt_reg == SCAN_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: sv/lcnc_dpath.sv
`timescale 1ns / 1ps

module lcnc_dpath
    import lcnc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CARD_W-1:0]  card_number,
    input  lcnc_cmd_t          cmd,
    output lcnc_status_t       status,
    output logic               class_valid,
    input  logic               class_ready,
    output logic [CLASS_W-1:0] card_class
);

    logic [BIN_W-1:0]   bin_reg;
    logic [BIN_W-1:0]   bin_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_next;
    logic [3:0]         sum_reg;
    logic [3:0]         sum_next;
    logic [LEN_W-1:0]   pos_reg;
    logic [LEN_W-1:0]   count_reg;
    logic [LEN_W-1:0]   count_next;
    logic [3:0]         lead_reg;
    logic [3:0]         lead_next;
    logic [3:0]         sec_reg;
    logic [3:0]         sec_next;
    logic [3:0]         prev_hi_reg;
    logic [CLASS_W-1:0] class_reg;
    logic [CLASS_W-1:0] class_next;
    logic               out_valid_reg;

    logic [3:0] d_lo;
    logic [3:0] d_hi;
    logic [4:0] d_dbl;
    logic [4:0] acc;
    logic [4:0] acc_mod;

    // Binary to decimal conversion: four shift-and-adjust steps per cycle.
    always_comb
    begin
        logic [BIN_W-1:0] b;
        logic [BCD_W-1:0] d;
        b = bin_reg;
        d = bcd_reg;
        for (int s = 0; s < BITS_STEP; s++)
        begin
            for (int n = 0; n < NIBBLES; n++)
            begin
                if (d[n*4 +: 4] >= 4'd5)
                begin
                    d[n*4 +: 4] = d[n*4 +: 4] + 4'd3;
                end
            end
            d = {d[BCD_W-2:0], b[BIN_W-1]};
            b = {b[BIN_W-2:0], 1'b0};
        end
        bin_next = b;
        bcd_next = d;
    end

    assign d_lo     = bcd_reg[3:0];
    assign d_hi     = bcd_reg[7:4];
    assign d_dbl    = (d_hi >= 4'd5) ? ({d_hi, 1'b0} - 5'd9) : {d_hi, 1'b0};
    assign acc      = {1'b0, sum_reg} + {1'b0, d_lo} + d_dbl;
    assign acc_mod  = (acc >= 5'd20) ? (acc - 5'd20) :
                      (acc >= 5'd10) ? (acc - 5'd10) : acc;
    assign sum_next = acc_mod[3:0];

    always_comb
    begin
        count_next = count_reg;
        lead_next  = lead_reg;
        sec_next   = sec_reg;
        if (d_hi != 4'd0)
        begin
            count_next = pos_reg + 5'd2;
            lead_next  = d_hi;
            sec_next   = d_lo;
        end
        else if (d_lo != 4'd0)
        begin
            count_next = pos_reg + 5'd1;
            lead_next  = d_lo;
            sec_next   = prev_hi_reg;
        end
    end

    always_comb
    begin
        class_next = CLASS_INVALID;
        if ((sum_reg == 4'd0) && (count_reg inside {LEN_SHORT, LEN_AMEX, LEN_LONG}))
        begin
            if ((count_reg == LEN_AMEX) && (lead_reg == AMEX_LEAD) &&
                (sec_reg inside {AMEX_SEC_A, AMEX_SEC_B}))
            begin
                class_next = CLASS_AMEX;
            end
            else if ((count_reg == LEN_LONG) && (lead_reg == MC_LEAD) &&
                     (sec_reg inside {[MC_SEC_LO:MC_SEC_HI]}))
            begin
                class_next = CLASS_MC;
            end
            else if ((count_reg inside {LEN_SHORT, LEN_LONG}) &&
                     (lead_reg == VISA_LEAD))
            begin
                class_next = CLASS_VISA;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            bin_reg     <= {1'b0, card_number};
            bcd_reg     <= '0;
            sum_reg     <= '0;
            pos_reg     <= '0;
            count_reg   <= '0;
            lead_reg    <= '0;
            sec_reg     <= '0;
            prev_hi_reg <= '0;
        end
        else if (cmd.conv_step)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
        else if (cmd.scan_step)
        begin
            bcd_reg     <= {8'd0, bcd_reg[BCD_W-1:8]};
            sum_reg     <= sum_next;
            pos_reg     <= pos_reg + 5'd2;
            count_reg   <= count_next;
            lead_reg    <= lead_next;
            sec_reg     <= sec_next;
            prev_hi_reg <= d_hi;
        end
        if (cmd.emit)
        begin
            class_reg <= class_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (class_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || class_ready;
    assign class_valid     = out_valid_reg;
    assign card_class      = class_reg;

endmodule
